### hw/rtl/mhpq_pkg.sv
// Shared types, constants and helpers for the binary max-heap priority queue.
// Depends on nothing; mhpq_engine and the top level import it.
`default_nettype none

package mhpq_pkg;

    // Heap geometry. Slots run 1..CAPACITY with the root in slot 1.
    localparam int unsigned CAPACITY   = 1024;
    localparam int unsigned SLOT_W     = 11;
    localparam int unsigned VALUE_W    = 32;
    // Odd slots live in one bank, even slots in the other, so that two
    // siblings can be read in the same cycle.
    localparam int unsigned BANK_DEPTH = (CAPACITY + 1) / 2;
    localparam int unsigned BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] CAP_SLOTS = SLOT_W'(CAPACITY);
    localparam logic [SLOT_W-1:0] ROOT_SLOT = SLOT_W'(1);

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_CMP,
        S_POP_LAST,
        S_DOWN_CMP,
        S_WRITE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]                opcode;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [1:0]                status;
        logic [SLOT_W-1:0]         item_count;
        logic                      is_empty;
    } rsp_t;

    // Address of a slot inside its bank (bank is the slot's low bit).
    function automatic logic [BANK_AW-1:0] slot_addr(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] half;
        half = slot >> 1;
        if (!slot[0])
        begin
            half = half - SLOT_W'(1);
        end
        return half[BANK_AW-1:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/mhpq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module mhpq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 512,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mhpq_engine.sv
// Heap engine: state machine, fill count, root copy and two banked slot memories.
// Depends on mhpq_pkg and mhpq_ram.
`default_nettype none

module mhpq_engine
    import mhpq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic idle,
    output logic done,
    input  logic ack,
    output rsp_t rsp
);

    state_t                    state_reg, state_next;
    logic [SLOT_W-1:0]         count_reg, count_next;
    logic [SLOT_W-1:0]         pos_reg, pos_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic signed [VALUE_W-1:0] root_reg, root_next;
    logic signed [VALUE_W-1:0] res_val_reg, res_val_next;
    status_t                   status_reg, status_next;

    // Bank 0 holds even slots, bank 1 odd slots.
    logic [1:0]         rd_en;
    logic [BANK_AW-1:0] rd_addr [2];
    logic [VALUE_W-1:0] rd_data [2];
    logic [1:0]         wr_en;
    logic [BANK_AW-1:0] wr_addr [2];
    logic [VALUE_W-1:0] wr_data [2];

    logic [1:0]                rd_req;
    logic [SLOT_W-1:0]         rd_slot [2];
    logic                      wr_req;
    logic [SLOT_W-1:0]         wr_slot;
    logic signed [VALUE_W-1:0] wr_val;

    logic [SLOT_W-1:0]         new_slot;
    logic [SLOT_W-1:0]         parent_slot;
    logic [SLOT_W-1:0]         child_slot;
    logic signed [VALUE_W-1:0] parent_val;
    logic signed [VALUE_W-1:0] left_val;
    logic signed [VALUE_W-1:0] right_val;
    logic signed [VALUE_W-1:0] child_val;
    logic                      right_ok;

    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        mhpq_ram #(
            .WIDTH (VALUE_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk     (clk),
            .wr_en   (wr_en[b]),
            .wr_addr (wr_addr[b]),
            .wr_data (wr_data[b]),
            .rd_en   (rd_en[b]),
            .rd_addr (rd_addr[b]),
            .rd_data (rd_data[b])
        );
    end

    assign new_slot    = count_reg + SLOT_W'(1);
    assign parent_slot = pos_reg >> 1;
    // parent of pos sits in the bank given by pos bit 1
    assign parent_val  = pos_reg[1] ? rd_data[1] : rd_data[0];
    assign left_val    = rd_data[0];
    assign right_val   = rd_data[1];
    assign right_ok    = ({pos_reg[SLOT_W-2:0], 1'b0} != count_reg);
    // take the right child only when it is strictly greater
    assign child_slot  = {pos_reg[SLOT_W-2:0], (right_ok && (left_val < right_val))};
    assign child_val   = (right_ok && (left_val < right_val)) ? right_val : left_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        root_reg    <= root_next;
        res_val_reg <= res_val_next;
        status_reg  <= status_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        root_next    = root_reg;
        res_val_next = res_val_reg;
        status_next  = status_reg;
        rd_req       = '0;
        rd_slot[0]   = '0;
        rd_slot[1]   = '0;
        wr_req       = 1'b0;
        wr_slot      = '0;
        wr_val       = '0;
        idle         = 1'b0;
        done         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    res_val_next = '0;
                    status_next  = ST_OK;
                    state_next   = S_DONE;
                    unique case (op_t'(cmd.opcode))
                        OP_PUSH:
                        begin
                            if (count_reg >= CAP_SLOTS)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = new_slot;
                                pos_next   = new_slot;
                                val_next   = cmd.value;
                                if (new_slot == ROOT_SLOT)
                                begin
                                    wr_req  = 1'b1;
                                    wr_slot = ROOT_SLOT;
                                    wr_val  = cmd.value;
                                end
                                else
                                begin
                                    rd_req[new_slot[1]]  = 1'b1;
                                    rd_slot[new_slot[1]] = new_slot >> 1;
                                    state_next = S_PUSH_CMP;
                                end
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // root comes from its copy; fetch the last slot
                                res_val_next = root_reg;
                                pos_next     = count_reg;
                                count_next   = count_reg - SLOT_W'(1);
                                rd_req[count_reg[0]]  = 1'b1;
                                rd_slot[count_reg[0]] = count_reg;
                                state_next = S_POP_LAST;
                            end
                        end
                        OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                res_val_next = root_reg;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_PUSH_CMP:
            begin
                if (parent_val < val_reg)
                begin
                    // move parent down, climb one level
                    wr_req   = 1'b1;
                    wr_slot  = pos_reg;
                    wr_val   = parent_val;
                    pos_next = parent_slot;
                    if (parent_slot == ROOT_SLOT)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        rd_req[parent_slot[1]]  = 1'b1;
                        rd_slot[parent_slot[1]] = parent_slot >> 1;
                    end
                end
                else
                begin
                    wr_req     = 1'b1;
                    wr_slot    = pos_reg;
                    wr_val     = val_reg;
                    state_next = S_DONE;
                end
            end
            S_POP_LAST:
            begin
                val_next = pos_reg[0] ? rd_data[1] : rd_data[0];
                pos_next = ROOT_SLOT;
                if (count_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (count_reg == ROOT_SLOT)
                begin
                    wr_req     = 1'b1;
                    wr_slot    = ROOT_SLOT;
                    wr_val     = pos_reg[0] ? rd_data[1] : rd_data[0];
                    state_next = S_DONE;
                end
                else
                begin
                    rd_req     = 2'b11;
                    rd_slot[0] = SLOT_W'(2);
                    rd_slot[1] = SLOT_W'(3);
                    state_next = S_DOWN_CMP;
                end
            end
            S_DOWN_CMP:
            begin
                if (val_reg >= child_val)
                begin
                    wr_req     = 1'b1;
                    wr_slot    = pos_reg;
                    wr_val     = val_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    // lift child, descend; fetch both grandchildren at once
                    wr_req   = 1'b1;
                    wr_slot  = pos_reg;
                    wr_val   = child_val;
                    pos_next = child_slot;
                    if (child_slot <= (count_reg >> 1))
                    begin
                        rd_req     = 2'b11;
                        rd_slot[0] = {child_slot[SLOT_W-2:0], 1'b0};
                        rd_slot[1] = {child_slot[SLOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE:
            begin
                wr_req     = 1'b1;
                wr_slot    = pos_reg;
                wr_val     = val_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done = 1'b1;
                if (ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Map slot requests onto the banks. A write and a read in the same
        // cycle never hit the same slot, and a slot written in one cycle is
        // read no earlier than the next, so no forwarding path is needed.
        rd_en      = rd_req;
        rd_addr[0] = slot_addr(rd_slot[0]);
        rd_addr[1] = slot_addr(rd_slot[1]);
        wr_en      = '0;
        wr_en[wr_slot[0]] = wr_req;
        wr_addr[0] = slot_addr(wr_slot);
        wr_addr[1] = slot_addr(wr_slot);
        wr_data[0] = wr_val;
        wr_data[1] = wr_val;
        if (wr_req && (wr_slot == ROOT_SLOT))
        begin
            root_next = wr_val;
        end
    end

    assign rsp.result_value = res_val_reg;
    assign rsp.status       = status_reg;
    assign rsp.item_count   = count_reg;
    assign rsp.is_empty     = (count_reg == '0);

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_SLOTS)
        else $error("fill count above capacity");

    a_full_status : assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status_reg == ST_FULL)) |-> (count_reg == CAP_SLOTS))
        else $error("full status with room left");

    a_push_count : assert property (@(posedge clk) disable iff (!rst_n)
        (idle && start && (cmd.opcode == OP_PUSH) && (count_reg < CAP_SLOTS))
        |=> (count_reg == $past(count_reg) + SLOT_W'(1)))
        else $error("push did not grow the count");

    a_one_write : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(wr_en))
        else $error("both banks written in one cycle");

endmodule

`default_nettype wire

### hw/rtl/max_heap_priority_queue.sv
// Binary max-heap priority queue of signed 32-bit words, capacity 1024.
// Peek, error and unused opcode words go straight to the result; a push
// sifts up and a pop sifts down, one heap level per step. One word is in
// flight at a time; cmd_ready returns as the result enters the output register.
// Reset clears the fill count and control; slot memory stays undefined.
// Depends on mhpq_pkg and mhpq_engine.
`default_nettype none

module max_heap_priority_queue
    import mhpq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic eng_idle;
    logic eng_done;
    logic load;
    rsp_t eng_rsp;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg;

    // Take a new word whenever the engine is idle; the output register
    // decouples it from a stalled consumer.
    assign cmd_ready = eng_idle;

    // Advance the finished word into the output register when it is free
    // or drains in this cycle.
    assign load = eng_done && (!rsp_valid_reg || rsp_ready);

    mhpq_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd_valid && cmd_ready),
        .cmd   (cmd),
        .idle  (eng_idle),
        .done  (eng_done),
        .ack   (load),
        .rsp   (eng_rsp)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold payload unless a new word is loaded.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= eng_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("second word taken while one is in flight");

    a_rsp_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("rsp word changed or dropped while stalled");

    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |-> !load)
        else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for max_heap_priority_queue: drives push, pop, peek and
// unused-opcode words and checks every response against a behavioral heap.
// Depends on mhpq_pkg and the max_heap_priority_queue RTL.

module tb_top;
    import mhpq_pkg::*;

    // Cycle limit is many times the slowest legal run of all phases.
    localparam int unsigned CYCLE_LIMIT = 600000;
    // Length of the long receiver hold-off used to back the block up.
    localparam int unsigned HOLD_CYCLES = 400;
    // Keep the log short when the design is badly broken.
    localparam int unsigned MAX_PRINTED = 50;

    localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;

    logic clk;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;

    // Set by a test to make the receiver hold off; cleared by the receiver.
    bit hold_rsp  = 1'b0;
    // Set for the last part of the run: no idling on either side.
    bit quiet_run = 1'b0;

    // Behavioral heap: slots 1..heap_fill, root in slot 1.
    logic signed [VALUE_W-1:0] heap_slots [1:CAPACITY];
    int unsigned               heap_fill = 0;

    // Expected response words, oldest first.
    rsp_t expected_rsp_q [$];

    max_heap_priority_queue uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: end the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // Apply one command word to the behavioral heap and return the response
    // word it must produce.
    function automatic rsp_t heap_predict(input cmd_t w);
        rsp_t                      r;
        logic signed [VALUE_W-1:0] moved;
        int unsigned               pos;
        int unsigned               child;
        bit                        done;
        r = '0;
        r.status = ST_OK;
        if (w.opcode == OP_PUSH)
        begin
            if (heap_fill >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                // Sift up from the new last slot; stop on a tie or at the root.
                heap_fill = heap_fill + 1;
                pos = heap_fill;
                while (pos > 1 && heap_slots[pos / 2] < w.value)
                begin
                    heap_slots[pos] = heap_slots[pos / 2];
                    pos = pos / 2;
                end
                heap_slots[pos] = w.value;
            end
        end
        else if (w.opcode == OP_POP || w.opcode == OP_PEEK)
        begin
            if (heap_fill == 0)
            begin
                r.status = ST_EMPTY;
            end
            else if (w.opcode == OP_PEEK)
            begin
                r.result_value = heap_slots[1];
            end
            else
            begin
                // Move the last item to the root and sift down; the right
                // child wins only when strictly greater than the left one.
                r.result_value = heap_slots[1];
                moved = heap_slots[heap_fill];
                heap_fill = heap_fill - 1;
                pos = 1;
                done = 1'b0;
                while (!done && pos * 2 <= heap_fill)
                begin
                    child = pos * 2;
                    if (child != heap_fill && heap_slots[child] < heap_slots[child + 1])
                    begin
                        child = child + 1;
                    end
                    if (moved >= heap_slots[child])
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        heap_slots[pos] = heap_slots[child];
                        pos = child;
                    end
                end
                heap_slots[pos] = moved;
            end
        end
        r.item_count = SLOT_W'(heap_fill);
        r.is_empty   = (heap_fill == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
        begin
            $display("cycle %0d: %s got %0h expected %0h", cycle_count, field, got, want);
        end
    endtask

    // Offer one command word and hold it until the block takes it. The
    // caller is always just past a rising edge here, so valid is raised
    // with a single assignment and never dropped in the same step.
    task automatic send_word(input cmd_t w);
        cmd_valid <= 1'b1;
        cmd       <= w;
        @(posedge clk);
        while (!cmd_ready)
        begin
            @(posedge clk);
        end
        expected_rsp_q.push_back(heap_predict(w));
    endtask

    // Drop valid for a random burst now and then, except in the quiet part.
    task automatic sender_gap();
        if (!quiet_run && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic send_op(input op_t op, input logic signed [VALUE_W-1:0] v);
        cmd_t w;
        w.opcode = op;
        w.value  = v;
        sender_gap();
        send_word(w);
    endtask

    // Value mix: extremes, a narrow band that makes ties common, full range.
    function automatic logic signed [VALUE_W-1:0] random_value();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return INT_MAX;
        end
        else if (pick == 1)
        begin
            return INT_MIN;
        end
        else if (pick < 5)
        begin
            return $signed(VALUE_W'($urandom_range(0, 8))) - 4;
        end
        return $urandom;
    endfunction

    // Weighted random opcode; what is left of 100 goes to the unused opcode.
    task automatic send_random(input int unsigned push_w, input int unsigned pop_w,
                               input int unsigned peek_w);
        int unsigned roll;
        op_t         op;
        roll = $urandom_range(0, 99);
        if (roll < push_w)
        begin
            op = OP_PUSH;
        end
        else if (roll < push_w + pop_w)
        begin
            op = OP_POP;
        end
        else if (roll < push_w + pop_w + peek_w)
        begin
            op = OP_PEEK;
        end
        else
        begin
            op = OP_NOP;
        end
        send_op(op, random_value());
    endtask

    // Receiver: random ready bursts, the long hold-off on request, and
    // steady ready in the quiet part of the run.
    initial
    begin : receiver
        int unsigned held;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_rsp)
            begin
                rsp_ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_rsp = 1'b0;
            end
            else if (!quiet_run && $urandom_range(0, 3) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    end

    // Check every accepted response word against the oldest expectation.
    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                report_mismatch("unexpected rsp word, result_value", rsp.result_value, '0);
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp.result_value !== want.result_value)
                begin
                    report_mismatch("result_value", rsp.result_value, want.result_value);
                end
                if (rsp.status !== want.status)
                begin
                    report_mismatch("status", 32'(rsp.status), 32'(want.status));
                end
                if (rsp.item_count !== want.item_count)
                begin
                    report_mismatch("item_count", 32'(rsp.item_count), 32'(want.item_count));
                end
                if (rsp.is_empty !== want.is_empty)
                begin
                    report_mismatch("is_empty", 32'(rsp.is_empty), 32'(want.is_empty));
                end
            end
        end
    end

    // Pop and peek on an empty heap, the unused opcode, and a round trip
    // back to empty.
    task automatic test_empty_heap();
        send_op(OP_POP, 32'sd5);
        send_op(OP_PEEK, -32'sd1);
        send_op(OP_NOP, INT_MAX);
        send_op(OP_PUSH, 32'sd42);
        send_op(OP_NOP, INT_MIN);
        send_op(OP_POP, '0);
        send_op(OP_POP, '0);
    endtask

    // Extreme values go in and must come out in descending order.
    task automatic test_value_extremes();
        send_op(OP_PUSH, INT_MIN);
        send_op(OP_PUSH, 32'sd0);
        send_op(OP_PUSH, INT_MAX);
        send_op(OP_PUSH, -32'sd1);
        send_op(OP_PUSH, 32'sh5555_5555);
        send_op(OP_PEEK, 32'shAAAA_AAAA);
        repeat (5) send_op(OP_POP, '0);
    endtask

    // Equal keys: a push stops on an equal parent, a pop takes the left
    // child when both children match.
    task automatic test_ties();
        send_op(OP_PUSH, 32'sd7);
        send_op(OP_PUSH, 32'sd7);
        send_op(OP_PUSH, 32'sd7);
        send_op(OP_PUSH, 32'sd3);
        send_op(OP_PUSH, 32'sd7);
        send_op(OP_PUSH, 32'sd3);
        repeat (6) send_op(OP_POP, '0);
    endtask

    // Hold the receiver off while words keep coming, so the block backs up
    // and drops cmd_ready.
    task automatic test_backpressure();
        hold_rsp = 1'b1;
        repeat (30)
        begin
            cmd_t w;
            w.opcode = ($urandom_range(0, 2) == 0) ? OP_POP : OP_PUSH;
            w.value  = random_value();
            send_word(w);
        end
        while (hold_rsp)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_random_mix();
        repeat (40) send_random(45, 35, 15);
    endtask

    // Push-heavy traffic until the heap is full, then hit it while full.
    task automatic test_fill_and_overflow();
        while (heap_fill < CAPACITY)
        begin
            send_random(97, 1, 1);
        end
        repeat (12) send_random(75, 0, 15);
        send_op(OP_PUSH, INT_MAX);
        send_op(OP_PUSH, INT_MIN);
    endtask

    // Last part of the run, with no idling: pop-heavy traffic from the full
    // heap, so pops sift down from the root of a deep heap.
    task automatic test_drain();
        quiet_run = 1'b1;
        repeat (40) send_random(10, 60, 25);
    endtask

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_heap();
        test_value_extremes();
        test_ties();
        test_backpressure();
        test_random_mix();
        test_fill_and_overflow();
        test_drain();

        cmd_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
        begin
            @(posedge clk);
        end
        // Give a stray extra word time to show up.
        repeat (40) @(posedge clk);

        if (mismatch_count == 0 && expected_rsp_q.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
